>>> hw/rtl/lqsi_pkg.sv
// ---------------------------------------------------------------------------
// lqsi_pkg
// Shared types, sizes and arithmetic helpers for the luma quarter-sample
// interpolator.
// ---------------------------------------------------------------------------
`default_nettype none

package lqsi_pkg;

  localparam int BLOCK_SIZE = 16;
  localparam int WIN_W      = BLOCK_SIZE + 5;
  localparam int COL_W      = $clog2(WIN_W + 1);
  localparam int ADDR_W     = $clog2(WIN_W);
  localparam int POS_W      = 4;
  localparam int TAPS       = 6;
  localparam int LINES      = 5;
  localparam int LINE_W     = 8 * LINES;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int ODEPTH     = 8;
  localparam int OPTR_W     = $clog2(ODEPTH);

  typedef logic [7:0]         pix_t;
  typedef logic signed [14:0] tap_t;
  typedef logic signed [20:0] ctr_t;

  typedef enum logic [3:0] {
    POS_INT, POS_A, POS_B, POS_C,
    POS_D,   POS_E, POS_F, POS_G,
    POS_H,   POS_I, POS_J, POS_K,
    POS_N,   POS_P, POS_Q, POS_R
  } frac_pos_t;

  typedef struct packed {
    pix_t [TAPS-1:0][TAPS-1:0] win;
    frac_pos_t                 frac;
    logic [POS_W-1:0]          row;
    logic [POS_W-1:0]          col;
    logic                      last;
  } win_item_t;

  typedef struct packed {
    pix_t             pred;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic                push;
    logic                pop;
  } q_ctrl_t;

  function automatic tap_t tap6_s(pix_t a, pix_t b, pix_t c, pix_t d, pix_t e, pix_t f);
    tap_t sa, sb, sc, sd, se, sf;
    sa = tap_t'({7'd0, a});
    sb = tap_t'({7'd0, b});
    sc = tap_t'({7'd0, c});
    sd = tap_t'({7'd0, d});
    se = tap_t'({7'd0, e});
    sf = tap_t'({7'd0, f});
    return sa + sf - tap_t'(5) * (sb + se) + tap_t'(20) * (sc + sd);
  endfunction

  function automatic ctr_t tap6_w(tap_t a, tap_t b, tap_t c, tap_t d, tap_t e, tap_t f);
    ctr_t wa, wb, wc, wd, we, wf;
    wa = ctr_t'(a);
    wb = ctr_t'(b);
    wc = ctr_t'(c);
    wd = ctr_t'(d);
    we = ctr_t'(e);
    wf = ctr_t'(f);
    return wa + wf - ctr_t'(5) * (wb + we) + ctr_t'(20) * (wc + wd);
  endfunction

  function automatic pix_t clip5(tap_t v);
    logic signed [15:0] t;
    t = 16'(v) + 16'sd16;
    if (t < 0) return 8'd0;
    if (t[15:5] > 11'd255) return 8'd255;
    return t[12:5];
  endfunction

  function automatic pix_t clip10(ctr_t v);
    logic signed [21:0] t;
    t = 22'(v) + 22'sd512;
    if (t < 0) return 8'd0;
    if (t[21:10] > 12'd255) return 8'd255;
    return t[17:10];
  endfunction

  function automatic pix_t avg2(pix_t a, pix_t b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b} + 9'd1;
    return s[8:1];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lqsi_ram.sv
// ---------------------------------------------------------------------------
// lqsi_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module lqsi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/lqsi_front.sv
// ---------------------------------------------------------------------------
// lqsi_front
// Sample intake: position counters, five-line delay, 6x6 window and
// classification of which samples produce a prediction.
// ---------------------------------------------------------------------------
`default_nettype none

module lqsi_front import lqsi_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  output logic                 full,
  input  wire pix_t            ref_sample,
  input  wire logic [1:0]      frac_x,
  input  wire logic [1:0]      frac_y,
  input  wire logic            first_of_block,
  input  wire logic [QPTR_W:0] q_count,
  output logic                 q_push,
  output win_item_t            q_item
);

  logic [COL_W-1:0]          win_row, win_col, win_row_next, win_col_next;
  logic [COL_W-1:0]          cur_row, cur_col;
  frac_pos_t                 held_frac, cur_frac;
  logic                      accept;

  logic                      sa_valid, sa_emit, sa_last;
  pix_t                      sa_sample;
  logic [ADDR_W-1:0]         sa_col;
  frac_pos_t                 sa_frac;
  logic [POS_W-1:0]          sa_r, sa_c;
  logic [COL_W-1:0]          r_full, c_full;

  logic [LINE_W-1:0]         line_rd, line_wr;
  pix_t [TAPS-1:0][TAPS-1:0] window, window_next;

  assign full   = ({1'b0, q_count} + (QPTR_W+2)'(sa_valid)) >= (QPTR_W+2)'(QDEPTH);
  assign accept = push && !full;

  assign cur_row  = first_of_block ? '0 : win_row;
  assign cur_col  = first_of_block ? '0 : win_col;
  assign cur_frac = first_of_block ? frac_pos_t'({frac_y, frac_x}) : held_frac;
  assign r_full   = cur_row - COL_W'(5);
  assign c_full   = cur_col - COL_W'(5);

  always_comb begin
    if (cur_col == COL_W'(WIN_W - 1)) begin
      win_col_next = '0;
      win_row_next = (cur_row == COL_W'(WIN_W - 1)) ? '0 : cur_row + COL_W'(1);
    end else begin
      win_col_next = cur_col + COL_W'(1);
      win_row_next = cur_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_row   <= '0;
      win_col   <= '0;
      held_frac <= POS_INT;
      sa_valid  <= 1'b0;
    end else begin
      sa_valid <= accept;
      if (accept) begin
        win_row   <= win_row_next;
        win_col   <= win_col_next;
        held_frac <= cur_frac;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sa_sample <= ref_sample;
      sa_col    <= cur_col[ADDR_W-1:0];
      sa_emit   <= (cur_row >= COL_W'(5)) && (cur_col >= COL_W'(5));
      sa_frac   <= cur_frac;
      sa_r      <= r_full[POS_W-1:0];
      sa_c      <= c_full[POS_W-1:0];
      sa_last   <= (r_full[POS_W-1:0] == POS_W'(BLOCK_SIZE - 1)) &&
                   (c_full[POS_W-1:0] == POS_W'(BLOCK_SIZE - 1));
    end
  end

  lqsi_ram #(
    .WIDTH (LINE_W),
    .DEPTH (WIN_W)
  ) u_lines (
    .clk   (clk),
    .we    (sa_valid),
    .waddr (sa_col),
    .wdata (line_wr),
    .raddr (cur_col[ADDR_W-1:0]),
    .rdata (line_rd)
  );

  assign line_wr = {sa_sample, line_rd[LINE_W-1:8]};

  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      for (int j = 0; j < TAPS - 1; j++) begin
        window_next[i][j] = window[i][j+1];
      end
    end
    for (int i = 0; i < LINES; i++) begin
      window_next[i][TAPS-1] = line_rd[8*i +: 8];
    end
    window_next[TAPS-1][TAPS-1] = sa_sample;
  end

  always_ff @(posedge clk) begin
    if (sa_valid) begin
      window <= window_next;
    end
  end

  assign q_push      = sa_valid && sa_emit;
  assign q_item.win  = window_next;
  assign q_item.frac = sa_frac;
  assign q_item.row  = sa_r;
  assign q_item.col  = sa_c;
  assign q_item.last = sa_last;

endmodule

`default_nettype wire

>>> hw/rtl/lqsi_queue.sv
// ---------------------------------------------------------------------------
// lqsi_queue
// Short window queue between intake and filter.
// ---------------------------------------------------------------------------
`default_nettype none

module lqsi_queue import lqsi_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire q_ctrl_t   ctrl_in,
  input  wire win_item_t wr_item,
  output win_item_t      rd_item,
  output logic [QPTR_W:0] count
);

  win_item_t         slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;

  assign rd_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (ctrl_in.push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (ctrl_in.pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + (QPTR_W+1)'(ctrl_in.push) - (QPTR_W+1)'(ctrl_in.pop);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_in.push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    ctrl_in.push && !ctrl_in.pop |-> count < (QPTR_W+1)'(QDEPTH))
    else $error("window queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    ctrl_in.pop |-> count != '0)
    else $error("window queue underflow");

endmodule

`default_nettype wire

>>> hw/rtl/lqsi_back.sv
// ---------------------------------------------------------------------------
// lqsi_back
// Six-tap filter pipeline, quarter-position select and result queue.
// ---------------------------------------------------------------------------
`default_nettype none

module lqsi_back import lqsi_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic [QPTR_W:0] q_count,
  input  wire win_item_t       q_item,
  output logic                 q_pop,
  input  wire logic            pop,
  output logic                 empty,
  output out_item_t            head
);

  // stage 1: first filter pass
  logic                  s1_valid;
  tap_t [TAPS-1:0]       s1_vert;
  tap_t                  s1_hor2, s1_hor3;
  pix_t                  s1_g, s1_g_right, s1_g_below;
  frac_pos_t             s1_frac;
  logic [POS_W-1:0]      s1_row, s1_col;
  logic                  s1_last;

  // stage 2: half samples
  logic                  s2_valid;
  pix_t                  s2_b, s2_s, s2_h, s2_m;
  ctr_t                  s2_j1;
  pix_t                  s2_g, s2_g_right, s2_g_below;
  frac_pos_t             s2_frac;
  logic [POS_W-1:0]      s2_row, s2_col;
  logic                  s2_last;

  pix_t                  j_val, pred;

  out_item_t             slots [ODEPTH];
  logic [OPTR_W-1:0]     wr_ptr, rd_ptr;
  logic [OPTR_W:0]       ocount;
  logic                  out_pop;

  assign out_pop = pop && !empty;
  assign q_pop   = (q_count != '0) &&
                   (({1'b0, ocount} + (OPTR_W+2)'(s1_valid) + (OPTR_W+2)'(s2_valid))
                    < (OPTR_W+2)'(ODEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= q_pop;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < TAPS; k++) begin
      s1_vert[k] <= tap6_s(q_item.win[0][k], q_item.win[1][k], q_item.win[2][k],
                           q_item.win[3][k], q_item.win[4][k], q_item.win[5][k]);
    end
    s1_hor2    <= tap6_s(q_item.win[2][0], q_item.win[2][1], q_item.win[2][2],
                         q_item.win[2][3], q_item.win[2][4], q_item.win[2][5]);
    s1_hor3    <= tap6_s(q_item.win[3][0], q_item.win[3][1], q_item.win[3][2],
                         q_item.win[3][3], q_item.win[3][4], q_item.win[3][5]);
    s1_g       <= q_item.win[2][2];
    s1_g_right <= q_item.win[2][3];
    s1_g_below <= q_item.win[3][2];
    s1_frac    <= q_item.frac;
    s1_row     <= q_item.row;
    s1_col     <= q_item.col;
    s1_last    <= q_item.last;
  end

  always_ff @(posedge clk) begin
    s2_b       <= clip5(s1_hor2);
    s2_s       <= clip5(s1_hor3);
    s2_h       <= clip5(s1_vert[2]);
    s2_m       <= clip5(s1_vert[3]);
    s2_j1      <= tap6_w(s1_vert[0], s1_vert[1], s1_vert[2],
                         s1_vert[3], s1_vert[4], s1_vert[5]);
    s2_g       <= s1_g;
    s2_g_right <= s1_g_right;
    s2_g_below <= s1_g_below;
    s2_frac    <= s1_frac;
    s2_row     <= s1_row;
    s2_col     <= s1_col;
    s2_last    <= s1_last;
  end

  assign j_val = clip10(s2_j1);

  always_comb begin
    unique case (s2_frac)
      POS_INT: pred = s2_g;
      POS_A:   pred = avg2(s2_g, s2_b);
      POS_B:   pred = s2_b;
      POS_C:   pred = avg2(s2_g_right, s2_b);
      POS_D:   pred = avg2(s2_g, s2_h);
      POS_E:   pred = avg2(s2_b, s2_h);
      POS_F:   pred = avg2(s2_b, j_val);
      POS_G:   pred = avg2(s2_b, s2_m);
      POS_H:   pred = s2_h;
      POS_I:   pred = avg2(s2_h, j_val);
      POS_J:   pred = j_val;
      POS_K:   pred = avg2(j_val, s2_m);
      POS_N:   pred = avg2(s2_g_below, s2_h);
      POS_P:   pred = avg2(s2_h, s2_s);
      POS_Q:   pred = avg2(j_val, s2_s);
      POS_R:   pred = avg2(s2_m, s2_s);
      default: pred = s2_g;
    endcase
  end

  assign empty = (ocount == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      ocount <= '0;
    end else begin
      if (s2_valid) begin
        wr_ptr <= wr_ptr + OPTR_W'(1);
      end
      if (out_pop) begin
        rd_ptr <= rd_ptr + OPTR_W'(1);
      end
      ocount <= ocount + (OPTR_W+1)'(s2_valid) - (OPTR_W+1)'(out_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      slots[wr_ptr] <= '{pred: pred, row: s2_row, col: s2_col, last: s2_last};
    end
  end

  a_out_bound: assert property (@(posedge clk) disable iff (rst)
    ocount <= (OPTR_W+1)'(ODEPTH))
    else $error("result queue overflow");

  a_fill_follows: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> ##1 s2_valid)
    else $error("filter stage lost a transfer");

endmodule

`default_nettype wire

>>> hw/rtl/luma_quarter_sample_interpolator_top.sv
// ---------------------------------------------------------------------------
// luma_quarter_sample_interpolator_top
// Quarter-sample luma interpolator for one block from a streamed window.
//
//   channel   direction  handshake    payload
//   samples   in         push / full  ref_sample, frac_x, frac_y, first_of_block
//   results   out        pop / empty  pred_sample, out_row, out_col, last_of_block
//
// One sample transfer per cycle while full is low. Each sample that yields a result
// passes the intake stage with the registered line RAM read, the window queue,
// the two filter stages and the result queue before the result leaves.
// Reset clears counters, fraction and queues; window and line RAM are not
// cleared. full rises once the window queue and intake stage hold QDEPTH
// items; results stall only on pop.
// ---------------------------------------------------------------------------
`default_nettype none

module luma_quarter_sample_interpolator_top import lqsi_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [7:0]       ref_sample,
  input  wire logic [1:0]       frac_x,
  input  wire logic [1:0]       frac_y,
  input  wire logic             first_of_block,
  output logic                  empty,
  input  wire logic             pop,
  output logic [7:0]            pred_sample,
  output logic [POS_W-1:0]      out_row,
  output logic [POS_W-1:0]      out_col,
  output logic                  last_of_block
);

  q_ctrl_t         qc;
  logic            q_push, q_pop;
  logic [QPTR_W:0] q_count;
  win_item_t       q_wr, q_rd;
  out_item_t       head;

  assign qc = '{push: q_push, pop: q_pop};

  lqsi_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .ref_sample     (ref_sample),
    .frac_x         (frac_x),
    .frac_y         (frac_y),
    .first_of_block (first_of_block),
    .q_count        (q_count),
    .q_push         (q_push),
    .q_item         (q_wr)
  );

  lqsi_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .ctrl_in (qc),
    .wr_item (q_wr),
    .rd_item (q_rd),
    .count   (q_count)
  );

  lqsi_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_count (q_count),
    .q_item  (q_rd),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .head    (head)
  );

  assign pred_sample   = head.pred;
  assign out_row       = head.row;
  assign out_col       = head.col;
  assign last_of_block = head.last;

endmodule

`default_nettype wire

>>> tb/lqsi_checker.sv
// ---------------------------------------------------------------------------
// lqsi_checker
// Watches sample and result transfers of the luma quarter-sample
// interpolator, predicts each interpolated sample and compares it.
// ---------------------------------------------------------------------------
`default_nettype none

module lqsi_checker import lqsi_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic             full,
  input  wire logic [7:0]       ref_sample,
  input  wire logic [1:0]       frac_x,
  input  wire logic [1:0]       frac_y,
  input  wire logic             first_of_block,
  input  wire logic             empty,
  input  wire logic             pop,
  input  wire logic [7:0]       pred_sample,
  input  wire logic [POS_W-1:0] out_row,
  input  wire logic [POS_W-1:0] out_col,
  input  wire logic             last_of_block,
  output int                    fail_count,
  output int                    pending
);

  pix_t      lines [LINES][WIN_W];
  pix_t      win [TAPS][TAPS];
  int        cur_row, cur_col;
  frac_pos_t held_pos;
  out_item_t expected_q[$];

  assign pending = expected_q.size();

  function automatic int taps(int a, int b, int c, int d, int e, int f);
    return a - 5 * b + 20 * c + 20 * d - 5 * e + f;
  endfunction

  function automatic int rclip(int v, int bias, int sh);
    int t;
    t = v + bias;
    if (t < 0) return 0;
    t = t >>> sh;
    return (t > 255) ? 255 : t;
  endfunction

  function automatic int vsum(int c);
    return taps(win[0][c], win[1][c], win[2][c], win[3][c], win[4][c], win[5][c]);
  endfunction

  function automatic int hhalf(int r);
    return rclip(taps(win[r][0], win[r][1], win[r][2], win[r][3], win[r][4], win[r][5]),
                 16, 5);
  endfunction

  function automatic int vhalf(int c);
    return rclip(vsum(c), 16, 5);
  endfunction

  function automatic int chalf();
    return rclip(taps(vsum(0), vsum(1), vsum(2), vsum(3), vsum(4), vsum(5)), 512, 10);
  endfunction

  function automatic int mean2(int a, int b);
    return (a + b + 1) >> 1;
  endfunction

  function automatic int interp(frac_pos_t p);
    int g;
    g = win[2][2];
    case (p)
      POS_INT: return g;
      POS_A:   return mean2(g, hhalf(2));
      POS_B:   return hhalf(2);
      POS_C:   return mean2(win[2][3], hhalf(2));
      POS_D:   return mean2(g, vhalf(2));
      POS_E:   return mean2(hhalf(2), vhalf(2));
      POS_F:   return mean2(hhalf(2), chalf());
      POS_G:   return mean2(hhalf(2), vhalf(3));
      POS_H:   return vhalf(2);
      POS_I:   return mean2(vhalf(2), chalf());
      POS_J:   return chalf();
      POS_K:   return mean2(chalf(), vhalf(3));
      POS_N:   return mean2(win[3][2], vhalf(2));
      POS_P:   return mean2(vhalf(2), hhalf(3));
      POS_Q:   return mean2(chalf(), hhalf(3));
      default: return mean2(vhalf(3), hhalf(3));
    endcase
  endfunction

  task automatic predict_sample(pix_t s, logic [1:0] fx, logic [1:0] fy, logic first);
    out_item_t o;
    if (first) begin
      cur_row = 0;
      cur_col = 0;
      held_pos = frac_pos_t'({fy, fx});
    end
    for (int i = 0; i < TAPS; i++)
      for (int j = 0; j < TAPS - 1; j++) win[i][j] = win[i][j+1];
    for (int i = 0; i < LINES; i++) win[i][TAPS-1] = lines[i][cur_col];
    win[TAPS-1][TAPS-1] = s;
    for (int i = 0; i < LINES - 1; i++) lines[i][cur_col] = lines[i+1][cur_col];
    lines[LINES-1][cur_col] = s;
    if (cur_row >= 5 && cur_col >= 5) begin
      o.pred = pix_t'(interp(held_pos));
      o.row  = POS_W'(cur_row - 5);
      o.col  = POS_W'(cur_col - 5);
      o.last = (cur_row - 5 == BLOCK_SIZE - 1) && (cur_col - 5 == BLOCK_SIZE - 1);
      expected_q.push_back(o);
    end
    if (cur_col + 1 >= WIN_W) begin
      cur_col = 0;
      cur_row = (cur_row + 1 >= WIN_W) ? 0 : cur_row + 1;
    end else begin
      cur_col++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t e;
    int        errs;
    errs = 0;
    if (rst) begin
      cur_row = 0;
      cur_col = 0;
      held_pos = POS_INT;
      fail_count <= 0;
      expected_q.delete();
    end else begin
      if (!empty && pop) begin
        if (expected_q.size() == 0) begin
          $error("result transfer with none expected");
          errs++;
        end else begin
          e = expected_q.pop_front();
          if (pred_sample !== e.pred) begin
            $error("pred_sample exp %0d got %0d", e.pred, pred_sample);
            errs++;
          end
          if (out_row !== e.row) begin
            $error("out_row exp %0d got %0d", e.row, out_row);
            errs++;
          end
          if (out_col !== e.col) begin
            $error("out_col exp %0d got %0d", e.col, out_col);
            errs++;
          end
          if (last_of_block !== e.last) begin
            $error("last_of_block exp %0d got %0d", e.last, last_of_block);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      if (push && !full) predict_sample(ref_sample, frac_x, frac_y, first_of_block);
    end
  end

endmodule

`default_nettype wire

>>> tb/tb_luma_quarter_sample_interpolator_top.sv
// ---------------------------------------------------------------------------
// tb_luma_quarter_sample_interpolator_top
// Streams whole and broken reference windows with random fractions and
// random gaps into the interpolator; the checker compares every result.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_luma_quarter_sample_interpolator_top;
  import lqsi_pkg::*;

  localparam int WIN_ITEMS = WIN_W * WIN_W;
  localparam int PART_ITEMS = 120;
  localparam int STALL_LIMIT = 5000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             push = 1'b0;
  logic             full;
  logic [7:0]       ref_sample = '0;
  logic [1:0]       frac_x = '0;
  logic [1:0]       frac_y = '0;
  logic             first_of_block = 1'b0;
  logic             empty;
  logic             pop = 1'b0;
  logic [7:0]       pred_sample;
  logic [POS_W-1:0] out_row;
  logic [POS_W-1:0] out_col;
  logic             last_of_block;
  int               fail_count, pending;
  int               quiet_cycles = 0;
  bit               sender_done = 1'b0;
  bit               hold_off = 1'b0;
  bit               calm = 1'b0;

  always #5 clk = ~clk;

  luma_quarter_sample_interpolator_top u_dut (.*);

  lqsi_checker u_checker (.*);

  task automatic send_sample(pix_t s, logic [1:0] fx, logic [1:0] fy, logic first);
    push <= 1'b1;
    ref_sample <= s;
    frac_x <= fx;
    frac_y <= fy;
    first_of_block <= first;
    @(posedge clk);
    while (full) @(posedge clk);
    if (!calm && $urandom_range(99) < 14) begin
      push <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 30) @(posedge clk);
    end
  endtask

  // mode 0 random, 1 all zero, 2 all max, 3 checker of extremes
  task automatic send_window(int mode, logic [1:0] fx, logic [1:0] fy, int count,
                             bit mark);
    pix_t s;
    for (int k = 0; k < count; k++) begin
      case (mode)
        1: s = 8'd0;
        2: s = 8'd255;
        3: s = ((k / WIN_W + k % WIN_W) % 2) ? 8'd255 : 8'd0;
        default: s = pix_t'($urandom_range(255));
      endcase
      send_sample(s, (k == 0) ? fx : 2'($urandom_range(3)),
                  (k == 0) ? fy : 2'($urandom_range(3)), (k == 0) && mark);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // unmarked start after reset uses fraction zero
    send_window(0, 2'd3, 2'd3, PART_ITEMS, 1'b0);
    // whole window without gaps, begun while the receiver holds off
    calm = 1'b1;
    hold_off = 1'b1;
    send_window(3, 2'd2, 2'd2, WIN_ITEMS, 1'b1);
    calm = 1'b0;
    // wrap into next window with held fraction
    send_window(0, 2'd0, 2'd0, PART_ITEMS, 1'b0);
    for (int p = 0; p < 6; p++)
      send_window(p % 4, 2'((p * 5 + 2) % 16), 2'(((p * 5 + 2) % 16) >> 2),
                  PART_ITEMS, 1'b1);
    push <= 1'b0;
    sender_done = 1'b1;
  end

  initial begin
    wait (hold_off);
    repeat (200) @(posedge clk);
    hold_off = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || hold_off) pop <= 1'b0;
    else pop <= calm || ($urandom_range(99) >= 14);
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    wait (sender_done);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
hw/rtl/lqsi_pkg.sv
hw/rtl/lqsi_ram.sv
hw/rtl/lqsi_front.sv
hw/rtl/lqsi_queue.sv
hw/rtl/lqsi_back.sv
hw/rtl/luma_quarter_sample_interpolator_top.sv
tb/lqsi_checker.sv
tb/tb_luma_quarter_sample_interpolator_top.sv
